@@ rtl/wtd_pkg.sv @@
// Shared types, constants and helpers for the write throttle/debounce unit.
package wtd_pkg;

    localparam int GAP_BITS = 16;
    localparam logic [32:0] GapMaxWide = (33'd1 << GAP_BITS) - 33'd1;

    localparam int VALUE_BITS = 32;

    localparam logic [1:0] REQ_SUBMIT = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    localparam int ADDR_BITS = 3;
    localparam logic REG_MIN_GAP       = 1'b0;
    localparam logic REG_DEBOUNCE_MODE = 1'b1;

    localparam logic [15:0] MIN_GAP_RESET = 16'd100;

    typedef logic [GAP_BITS-1:0] gap_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [15:0] min_gap;
        logic        debounce_mode;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        value_t value;
    } result_t;

    function automatic gap_t eff_gap(input logic [15:0] min_gap);
        logic [32:0] wide;
        wide = 33'(min_gap);
        if (wide > GapMaxWide) begin
            return GapMaxWide[GAP_BITS-1:0];
        end
        return wide[GAP_BITS-1:0];
    endfunction

endpackage

@@ rtl/write_throttle_debounce_unit.sv @@
// Top level of the write throttle/debounce unit.
// Input stream: one word per request. s_tuser carries req_type (submit, tick,
// flush); s_tdata carries new_value, used only by a submit.
// Output stream: m_tdata carries the value to write; a word appears only when
// a request causes a write (zero or one per request, in request order).
// Configuration: APB-style port, min_gap at 0x0, debounce_mode at 0x4; pready
// is always high. The user writes it only while the stream is idle (unchecked).
// Throughput: one request per cycle while s_tready is high. The state update
// for a request is a single pass of compare and counter logic, so the next
// request can follow in the next cycle.
// A write's word goes to the output register that drives m_tvalid and m_tdata.
// Stall: a word arriving while the output is held parks in a one-entry skid;
// s_tready drops only while that skid is full; requests wait until it drains.
// Reset (synchronous, aresetn low): pending value, deadline, counters and the
// last-written record clear; min_gap returns to 100 and throttle mode is set.
module write_throttle_debounce_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] new_value
    input  logic [1:0]                    s_tuser,   // [1:0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [31:0] written_value
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wtd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import wtd_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    accept;
    value_t  out_value;

    assign accept  = s_tvalid && s_tready;
    assign m_tdata = out_value;

    wtd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wtd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .req_type  (s_tuser),
        .new_value (s_tdata),
        .cfg       (cfg),
        .result    (result)
    );

    wtd_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (out_value)
    );

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not cleared by reset");

    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("skid full while output register empty");

    a_write_shows_next: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |=> m_tvalid)
        else $error("write lost after accept");

    a_cfg_mode_write: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && paddr[2] == REG_DEBOUNCE_MODE
        |=> cfg.debounce_mode == $past(pwdata[0]))
        else $error("debounce mode write not taken");

endmodule

@@ rtl/wtd_cfg.sv @@
// APB-style configuration registers: minimum gap and debounce mode.
module wtd_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wtd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output wtd_pkg::cfg_t                cfg
);
    import wtd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_MIN_GAP:       cfg_next.min_gap = pwdata[15:0];
                REG_DEBOUNCE_MODE: cfg_next.debounce_mode = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MIN_GAP:       prdata = {16'd0, cfg_reg.min_gap};
            REG_DEBOUNCE_MODE: prdata = {31'd0, cfg_reg.debounce_mode};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_gap       <= MIN_GAP_RESET;
            cfg_reg.debounce_mode <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/wtd_core.sv @@
// Throttle/debounce state and the single-pass update for one word.
module wtd_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [1:0]          req_type,
    input  wtd_pkg::value_t     new_value,
    input  wtd_pkg::cfg_t       cfg,
    output wtd_pkg::result_t    result
);
    import wtd_pkg::*;

    logic   pending_valid_reg, pending_valid_next;
    value_t pending_value_reg, pending_value_next;
    logic   deadline_armed_reg, deadline_armed_next;
    gap_t   ticks_reg, ticks_next;
    logic   has_written_reg, has_written_next;
    value_t last_value_reg, last_value_next;
    gap_t   elapsed_reg, elapsed_next;

    gap_t   gap;
    gap_t   ticks_dec;
    logic   emit;
    value_t emit_value;
    logic   drop;

    assign gap = eff_gap(cfg.min_gap);

    always_comb begin
        pending_valid_next  = pending_valid_reg;
        pending_value_next  = pending_value_reg;
        deadline_armed_next = deadline_armed_reg;
        ticks_next          = ticks_reg;
        has_written_next    = has_written_reg;
        last_value_next     = last_value_reg;
        elapsed_next        = elapsed_reg;
        emit                = 1'b0;
        emit_value          = pending_value_reg;
        drop                = 1'b0;
        ticks_dec           = (ticks_reg != '0) ? ticks_reg - gap_t'(1) : '0;

        case (req_type)
            REQ_SUBMIT: begin
                pending_value_next = new_value;
                pending_valid_next = 1'b1;
                emit_value         = new_value;
                if (!cfg.debounce_mode) begin
                    if (!has_written_reg || elapsed_reg >= gap) begin
                        emit = 1'b1;
                    end else begin
                        ticks_next          = gap - elapsed_reg;
                        deadline_armed_next = 1'b1;
                    end
                end else begin
                    ticks_next          = gap;
                    deadline_armed_next = 1'b1;
                end
            end
            REQ_TICK: begin
                elapsed_next = (elapsed_reg < gap) ? elapsed_reg + gap_t'(1) : gap;
                if (pending_valid_reg && deadline_armed_reg) begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == '0) begin
                        if (!has_written_reg || pending_value_reg != last_value_reg) begin
                            emit = 1'b1;
                        end else begin
                            drop = 1'b1;
                        end
                    end
                end
            end
            REQ_FLUSH: begin
                emit = pending_valid_reg;
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        if (drop) begin
            pending_valid_next  = 1'b0;
            deadline_armed_next = 1'b0;
        end
        if (emit) begin
            has_written_next    = 1'b1;
            last_value_next     = emit_value;
            elapsed_next        = '0;
            pending_valid_next  = 1'b0;
            deadline_armed_next = 1'b0;
            ticks_next          = '0;
        end
    end

    assign result.valid = accept && emit;
    assign result.value = emit_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_valid_reg  <= 1'b0;
            pending_value_reg  <= '0;
            deadline_armed_reg <= 1'b0;
            ticks_reg          <= '0;
            has_written_reg    <= 1'b0;
            last_value_reg     <= '0;
            elapsed_reg        <= '0;
        end else if (accept) begin
            pending_valid_reg  <= pending_valid_next;
            pending_value_reg  <= pending_value_next;
            deadline_armed_reg <= deadline_armed_next;
            ticks_reg          <= ticks_next;
            has_written_reg    <= has_written_next;
            last_value_reg     <= last_value_next;
            elapsed_reg        <= elapsed_next;
        end
    end

endmodule

@@ rtl/wtd_out_skid.sv @@
// Output register with one skid entry for the result channel.
module wtd_out_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  wtd_pkg::result_t  push,
    output logic              in_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output wtd_pkg::value_t   m_tdata
);
    import wtd_pkg::*;

    logic   main_valid_reg, main_valid_next;
    value_t main_data_reg, main_data_next;
    logic   skid_valid_reg, skid_valid_next;
    value_t skid_data_reg, skid_data_next;

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push.valid) begin
            if (!main_valid_reg || m_tready) begin
                main_valid_next = 1'b1;
                main_data_next  = push.value;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push.value;
            end
        end else if (m_tready) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
